// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// shared types, sizes, codes and helpers of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY  = 64;
  localparam int COST_W    = 32;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int ID_W      = 16;
  localparam int IN_COST_W = 32;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 3;
  localparam int POS_W     = 7;

  typedef logic [COST_W-1:0]    cost_t;
  typedef logic [ID_W-1:0]      id_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [IN_COST_W-1:0] in_cost_t;
  typedef logic [CAPACITY-1:0]  flag_vec_t;

  localparam mode_t MODE_INSERT   = 2'd0;
  localparam mode_t MODE_POP      = 2'd1;
  localparam mode_t MODE_DECREASE = 2'd2;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_EMPTY     = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_NOT_FOUND = 3'd3;
  localparam status_t ST_BAD_KEY   = 3'd4;

  // shift command broadcast to every cell
  typedef struct packed {
    logic  pop;
    logic  ins;
    cnt_t  at;
    cnt_t  upper;
    cost_t cost;
    id_t   id;
  } cell_cmd_t;

  typedef struct packed {
    id_t      top_id;
    in_cost_t top_cost;
    status_t  status;
    pos_t     position;
    logic     is_empty;
  } rsp_t;

  function automatic cost_t to_cost(input in_cost_t x);
    logic [COST_W+IN_COST_W-1:0] t;
    t = {{COST_W{1'b0}}, x};
    return t[COST_W-1:0];
  endfunction

  function automatic in_cost_t to_out_cost(input cost_t x);
    logic [COST_W+IN_COST_W-1:0] t;
    t = {{IN_COST_W{1'b0}}, x};
    return t[IN_COST_W-1:0];
  endfunction

  function automatic pos_t to_pos(input cnt_t x);
    logic [CNT_W+POS_W-1:0] t;
    t = {{POS_W{1'b0}}, x};
    return t[POS_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/spq_req_if.sv =====
// ----------------------------------------------------------------------------
// spq_req_if
// request channel of the sorted priority queue
// ----------------------------------------------------------------------------
interface spq_req_if;

  logic                valid;
  logic                ready;
  spq_pkg::mode_t      mode;
  spq_pkg::id_t        node_id;
  spq_pkg::in_cost_t   cost;
  spq_pkg::in_cost_t   lowered_cost;

  modport source (output valid, output mode, output node_id, output cost, output lowered_cost,
                  input ready);
  modport sink   (input valid, input mode, input node_id, input cost, input lowered_cost,
                  output ready);

endinterface

// ===== hw/rtl/spq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// spq_rsp_if
// result channel of the sorted priority queue
// ----------------------------------------------------------------------------
interface spq_rsp_if;

  logic                valid;
  logic                ready;
  spq_pkg::id_t        top_id;
  spq_pkg::in_cost_t   top_cost;
  spq_pkg::status_t    status;
  spq_pkg::pos_t       position;
  logic                is_empty;

  modport source (output valid, output top_id, output top_cost, output status,
                  output position, output is_empty, input ready);
  modport sink   (input valid, input top_id, input top_cost, input status,
                  input position, input is_empty, output ready);

endinterface

// ===== hw/rtl/sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// min-priority queue kept as a row of cells sorted by ascending cost
//
//   port    dir  handshake     carries
//   req_i   in   valid/ready   mode, node_id, cost, lowered_cost
//   rsp_o   out  valid/ready   top_id, top_cost, status, position, is_empty
//
// one request in flight; pop, unused mode and full/empty errors pass IDLE, EXEC and RES
// insert passes IDLE, EXEC, the bisection steps in BIS and then RES
// decrease key adds the equal-cost id scan in UP and DN, a WAIT state for the flags and a second bisection
// the bisection sequencer in spq_ctrl takes one step per cycle
// reset clears the state, the fill count and the output valid only; a result register lets rsp_o stall freely
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  spq_pkg::cell_cmd_t  cmd;
  spq_pkg::cost_t      target;
  spq_pkg::id_t        match_id;
  spq_pkg::flag_vec_t  lt_v, eq_v, idm_v;
  spq_pkg::cost_t      cell_cost [spq_pkg::CAPACITY];
  spq_pkg::id_t        cell_id   [spq_pkg::CAPACITY];
  logic                res_valid, res_ready;
  spq_pkg::rsp_t       res;
  logic                out_valid_q, out_valid_d;
  spq_pkg::rsp_t       out_q;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .lt_i        (lt_v),
    .eq_i        (eq_v),
    .idm_i       (idm_v),
    .head_cost_i (cell_cost[0]),
    .head_id_i   (cell_id[0]),
    .res_ready_i (res_ready),
    .cmd_o       (cmd),
    .target_o    (target),
    .match_id_o  (match_id),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  for (genvar g = 0; g < spq_pkg::CAPACITY; g++) begin : g_cell
    spq_pkg::cost_t prev_cost, next_cost;
    spq_pkg::id_t   prev_id, next_id;

    if (g == 0) begin : g_first
      assign prev_cost = cmd.cost;
      assign prev_id   = cmd.id;
    end else begin : g_mid_prev
      assign prev_cost = cell_cost[g-1];
      assign prev_id   = cell_id[g-1];
    end

    if (g == spq_pkg::CAPACITY - 1) begin : g_last
      assign next_cost = cell_cost[g];
      assign next_id   = cell_id[g];
    end else begin : g_mid_next
      assign next_cost = cell_cost[g+1];
      assign next_id   = cell_id[g+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (spq_pkg::idx_t'(g)),
      .cmd_i       (cmd),
      .prev_cost_i (prev_cost),
      .prev_id_i   (prev_id),
      .next_cost_i (next_cost),
      .next_id_i   (next_id),
      .target_i    (target),
      .match_id_i  (match_id),
      .cost_o      (cell_cost[g]),
      .id_o        (cell_id[g]),
      .lt_o        (lt_v[g]),
      .eq_o        (eq_v[g]),
      .idm_o       (idm_v[g])
    );
  end

  // result register
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.top_id   = out_q.top_id;
  assign rsp_o.top_cost = out_q.top_cost;
  assign rsp_o.status   = out_q.status;
  assign rsp_o.position = out_q.position;
  assign rsp_o.is_empty = out_q.is_empty;

endmodule

// ===== hw/rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// one queue entry: holds id and cost, shifts with its neighbours and
// registers its compare flags against the broadcast key
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::idx_t       idx_i,
  input  spq_pkg::cell_cmd_t  cmd_i,
  input  spq_pkg::cost_t      prev_cost_i,
  input  spq_pkg::id_t        prev_id_i,
  input  spq_pkg::cost_t      next_cost_i,
  input  spq_pkg::id_t        next_id_i,
  input  spq_pkg::cost_t      target_i,
  input  spq_pkg::id_t        match_id_i,
  output spq_pkg::cost_t      cost_o,
  output spq_pkg::id_t        id_o,
  output logic                lt_o,
  output logic                eq_o,
  output logic                idm_o
);

  spq_pkg::cost_t cost_q, cost_d;
  spq_pkg::id_t   id_q, id_d;
  spq_pkg::cnt_t  my_idx;
  logic           lt_q, eq_q, idm_q;

  assign my_idx = spq_pkg::cnt_t'(idx_i);

  always_comb begin
    cost_d = cost_q;
    id_d   = id_q;
    if (cmd_i.pop) begin
      cost_d = next_cost_i;
      id_d   = next_id_i;
    end else if (cmd_i.ins) begin
      if (my_idx == cmd_i.at) begin
        cost_d = cmd_i.cost;
        id_d   = cmd_i.id;
      end else if (my_idx > cmd_i.at && my_idx <= cmd_i.upper) begin
        cost_d = prev_cost_i;
        id_d   = prev_id_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cost_q <= cost_d;
    id_q   <= id_d;
    lt_q   <= cost_q < target_i;
    eq_q   <= cost_q == target_i;
    idm_q  <= id_q == match_id_i;
  end

  assign cost_o = cost_q;
  assign id_o   = id_q;
  assign lt_o   = lt_q;
  assign eq_o   = eq_q;
  assign idm_o  = idm_q;

endmodule

// ===== hw/rtl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// sequencer: bisection over the cell flags, id scan for decrease key,
// shift commands to the cell row and result build
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  spq_req_if.sink               req_i,
  input  spq_pkg::flag_vec_t    lt_i,
  input  spq_pkg::flag_vec_t    eq_i,
  input  spq_pkg::flag_vec_t    idm_i,
  input  spq_pkg::cost_t        head_cost_i,
  input  spq_pkg::id_t          head_id_i,
  input  logic                  res_ready_i,
  output spq_pkg::cell_cmd_t    cmd_o,
  output spq_pkg::cost_t        target_o,
  output spq_pkg::id_t          match_id_o,
  output logic                  res_valid_o,
  output spq_pkg::rsp_t         res_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_BIS  = 3'd2;
  localparam logic [2:0] S_UP   = 3'd3;
  localparam logic [2:0] S_DN   = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;
  localparam logic [2:0] S_RES  = 3'd6;

  logic [2:0]      state_q, state_d;
  spq_pkg::cnt_t   cnt_q, cnt_d;
  spq_pkg::mode_t  mode_q, mode_d;
  spq_pkg::id_t    id_q, id_d;
  spq_pkg::cost_t  cost_q, cost_d;
  spq_pkg::cost_t  ncost_q, ncost_d;
  spq_pkg::cost_t  target_q, target_d;
  spq_pkg::cnt_t   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  spq_pkg::cnt_t   i_q, i_d, idx_q, idx_d;
  logic            second_q, second_d;
  spq_pkg::rsp_t   res_q, res_d, res_base;

  spq_pkg::cnt_t   lo_n, hi_n, i_m1;
  logic [spq_pkg::CNT_W:0] mid_sum;
  spq_pkg::idx_t   mid_idx, i_idx, im1_idx;
  logic            bis_done, hit, miss;
  spq_pkg::cnt_t   hit_at;

  assign mid_idx = mid_q[spq_pkg::IDX_W-1:0];
  assign i_idx   = i_q[spq_pkg::IDX_W-1:0];
  assign i_m1    = i_q - spq_pkg::cnt_t'(1);
  assign im1_idx = i_m1[spq_pkg::IDX_W-1:0];

  // one bisection step
  always_comb begin
    if (lt_i[mid_idx]) begin
      lo_n = (lo_q == mid_q) ? lo_q + spq_pkg::cnt_t'(1) : mid_q;
      hi_n = hi_q;
    end else begin
      lo_n = lo_q;
      hi_n = mid_q;
    end
    mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
  end

  assign bis_done = (lo_q == hi_q) || eq_i[mid_idx];

  always_comb begin
    res_base          = '0;
    res_base.status   = spq_pkg::ST_OK;
    res_base.is_empty = (cnt_q == '0);
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    mode_d   = mode_q;
    id_d     = id_q;
    cost_d   = cost_q;
    ncost_d  = ncost_q;
    target_d = target_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    i_d      = i_q;
    idx_d    = idx_q;
    second_d = second_q;
    res_d    = res_q;
    cmd_o    = '0;
    hit      = 1'b0;
    miss     = 1'b0;
    hit_at   = i_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          mode_d   = req_i.mode;
          id_d     = req_i.node_id;
          cost_d   = spq_pkg::to_cost(req_i.cost);
          ncost_d  = spq_pkg::to_cost(req_i.lowered_cost);
          target_d = spq_pkg::to_cost(req_i.cost);
          lo_d     = '0;
          hi_d     = cnt_q;
          mid_d    = cnt_q >> 1;
          second_d = 1'b0;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (mode_q)
          spq_pkg::MODE_INSERT: begin
            if (cnt_q == spq_pkg::cnt_t'(spq_pkg::CAPACITY)) begin
              res_d        = res_base;
              res_d.status = spq_pkg::ST_FULL;
              state_d      = S_RES;
            end else begin
              state_d = S_BIS;
            end
          end
          spq_pkg::MODE_POP: begin
            res_d = res_base;
            if (cnt_q == '0) begin
              res_d.status = spq_pkg::ST_EMPTY;
            end else begin
              cmd_o.pop      = 1'b1;
              cnt_d          = cnt_q - spq_pkg::cnt_t'(1);
              res_d.top_id   = head_id_i;
              res_d.top_cost = spq_pkg::to_out_cost(head_cost_i);
              res_d.is_empty = (cnt_q == spq_pkg::cnt_t'(1));
            end
            state_d = S_RES;
          end
          spq_pkg::MODE_DECREASE: begin
            state_d = S_BIS;
          end
          default: begin
            res_d   = res_base;
            state_d = S_RES;
          end
        endcase
      end
      S_BIS: begin
        if (bis_done) begin
          if (mode_q == spq_pkg::MODE_INSERT) begin
            cmd_o.ins      = 1'b1;
            cmd_o.at       = mid_q;
            cmd_o.upper    = cnt_q;
            cmd_o.cost     = cost_q;
            cmd_o.id       = id_q;
            cnt_d          = cnt_q + spq_pkg::cnt_t'(1);
            res_d          = res_base;
            res_d.position = spq_pkg::to_pos(mid_q);
            res_d.is_empty = 1'b0;
            state_d        = S_RES;
          end else if (!second_q) begin
            if (lo_q == hi_q) begin
              miss = 1'b1;
            end else begin
              i_d     = mid_q;
              state_d = S_UP;
            end
          end else begin
            cmd_o.ins      = 1'b1;
            cmd_o.at       = mid_q;
            cmd_o.upper    = idx_q;
            cmd_o.cost     = ncost_q;
            cmd_o.id       = id_q;
            res_d          = res_base;
            res_d.position = spq_pkg::to_pos(mid_q);
            state_d        = S_RES;
          end
        end else begin
          lo_d  = lo_n;
          hi_d  = hi_n;
          mid_d = mid_sum[spq_pkg::CNT_W:1];
        end
      end
      S_UP: begin
        if (i_q < hi_q) begin
          if (idm_i[i_idx]) begin
            hit    = 1'b1;
            hit_at = i_q;
          end else if (!eq_i[i_idx]) begin
            i_d     = mid_q;
            state_d = S_DN;
          end else begin
            i_d = i_q + spq_pkg::cnt_t'(1);
          end
        end else begin
          i_d     = mid_q;
          state_d = S_DN;
        end
      end
      S_DN: begin
        if (i_q > lo_q) begin
          if (idm_i[im1_idx]) begin
            hit    = 1'b1;
            hit_at = i_m1;
          end else if (!eq_i[im1_idx]) begin
            miss = 1'b1;
          end else begin
            i_d = i_m1;
          end
        end else begin
          miss = 1'b1;
        end
      end
      S_WAIT: begin
        state_d = S_BIS;
      end
      S_RES: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (miss) begin
      res_d        = res_base;
      res_d.status = spq_pkg::ST_NOT_FOUND;
      state_d      = S_RES;
    end

    if (hit) begin
      idx_d = hit_at;
      if (ncost_q > cost_q) begin
        res_d        = res_base;
        res_d.status = spq_pkg::ST_BAD_KEY;
        state_d      = S_RES;
      end else begin
        target_d = ncost_q;
        lo_d     = '0;
        hi_d     = hit_at;
        mid_d    = hit_at >> 1;
        second_d = 1'b1;
        state_d  = S_WAIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    id_q     <= id_d;
    cost_q   <= cost_d;
    ncost_q  <= ncost_d;
    target_q <= target_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    i_q      <= i_d;
    idx_q    <= idx_d;
    second_q <= second_d;
    res_q    <= res_d;
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign target_o    = target_q;
  assign match_id_o  = id_q;
  assign res_valid_o = (state_q == S_RES);
  assign res_o       = res_q;

  // fill level never passes capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= spq_pkg::cnt_t'(spq_pkg::CAPACITY))
    else $error("entry count above capacity");

  // pop only on a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |-> cnt_q != '0)
    else $error("pop on empty queue");

  // bisection window stays ordered
  a_bis_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BIS) |-> (lo_q <= hi_q && mid_q <= hi_q))
    else $error("bisection window inverted");

  // every shift ends the operation
  a_shift_then_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.pop || cmd_o.ins) |=> state_q == S_RES)
    else $error("shift without result");

  // upward scan stays inside the window
  a_scan_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP) |-> (i_q >= mid_q && i_q <= hi_q))
    else $error("upward scan out of window");

endmodule
